/* rtl/tfpd_pkg.sv */
package tfpd_pkg;

	localparam int CFG_W       = 16;
	localparam int GAIN_W      = 16;
	localparam int CNT_W       = $clog2(GAIN_W);
	localparam int SAMPLE_FRAC = 6;
	localparam int ANGLE_SHIFT = 2;
	localparam int FRAC_DRV    = 24;
	localparam int DUTY_W      = 7;
	localparam int DRIVE_W     = 8;
	localparam int TILT_W      = 32;
	localparam int APB_ADDR_W  = 5;
	localparam int APB_DATA_W  = 32;
	localparam int REG_IDX_W   = 3;

	localparam logic [REG_IDX_W-1:0] REG_ACCEL_OFFSET = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GYRO_OFFSET  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ACCEL_GAIN   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GYRO_GAIN    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FUSION_GAIN  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_STEP_TIME    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_ANGLE_GAIN   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_RATE_GAIN    = 3'd7;

	localparam logic [CFG_W-1:0] RST_ACCEL_OFFSET = 16'd19431;
	localparam logic [CFG_W-1:0] RST_GYRO_OFFSET  = 16'd22272;
	localparam logic [CFG_W-1:0] RST_ACCEL_GAIN   = 16'd2259;
	localparam logic [CFG_W-1:0] RST_GYRO_GAIN    = 16'd17613;
	localparam logic [CFG_W-1:0] RST_FUSION_GAIN  = 16'd21845;
	localparam logic [CFG_W-1:0] RST_STEP_TIME    = 16'd328;
	localparam logic [CFG_W-1:0] RST_ANGLE_GAIN   = 16'd2816;
	localparam logic [CFG_W-1:0] RST_RATE_GAIN    = 16'd77;

	typedef struct packed {
		logic [CFG_W-1:0] accel_offset;
		logic [CFG_W-1:0] gyro_offset;
		logic [CFG_W-1:0] accel_gain;
		logic [CFG_W-1:0] gyro_gain;
		logic [CFG_W-1:0] fusion_gain;
		logic [CFG_W-1:0] step_time;
		logic [CFG_W-1:0] angle_gain;
		logic [CFG_W-1:0] rate_gain;
	} cfg_t;

endpackage

/* rtl/tfpd_stream_if.sv */
interface tfpd_sample_if #(parameter int SAMPLE_BITS = 10);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] accel_sample;
	logic [SAMPLE_BITS-1:0] gyro_sample;

	modport source (output valid, output accel_sample, output gyro_sample, input ready);
	modport sink   (input valid, input accel_sample, input gyro_sample, output ready);
endinterface

interface tfpd_cmd_if import tfpd_pkg::*; ;
	logic                      valid;
	logic                      ready;
	logic                      motor_reverse;
	logic [DUTY_W-1:0]         motor_duty;
	logic signed [DRIVE_W-1:0] drive_value;
	logic signed [TILT_W-1:0]  tilt_estimate;

	modport source (output valid, output motor_reverse, output motor_duty,
		output drive_value, output tilt_estimate, input ready);
	modport sink   (input valid, input motor_reverse, input motor_duty,
		input drive_value, input tilt_estimate, output ready);
endinterface

/* rtl/tilt_fusion_pd_motor_drive_core.sv */
// channel    dir  handshake      payload
// samples    in   valid/ready    accel_sample, gyro_sample
// commands   out  valid/ready    motor_reverse, motor_duty, drive_value, tilt_estimate
// apb        in   psel/penable   paddr, pwdata, prdata (pready tied high)
//
// one request makes four passes through two shift-add multipliers,
// one gain bit per cycle, plus load steps
// samples.ready is high only while no request is being worked on
// a result waiting on commands does not hold off the next request until it must be stored
// arst_n clears the tilt estimate, the held motor command and the registers to reset values
module tilt_fusion_pd_motor_drive_core import tfpd_pkg::*; #(
	parameter int DRIVE_LIMIT = 100,
	parameter int SAMPLE_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tfpd_sample_if.sink           samples,
	tfpd_cmd_if.source            commands,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int SHIFTED_W = SAMPLE_BITS + SAMPLE_FRAC;
	localparam int DIFF_W    = ((SHIFTED_W > CFG_W) ? SHIFTED_W : CFG_W) + 1;
	localparam int ANGLE_W   = DIFF_W + GAIN_W - ANGLE_SHIFT;
	localparam int VAL_W     = ((ANGLE_W > TILT_W) ? ANGLE_W : TILT_W) + 4;
	localparam int PRD_W     = VAL_W + GAIN_W;

	localparam logic signed [PRD_W-1:0] LIM     = PRD_W'(DRIVE_LIMIT) << FRAC_DRV;
	localparam logic signed [PRD_W-1:0] NEG_LIM = -LIM;

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_MUL_SENS  = 4'd1;
	localparam logic [3:0] ST_LOAD_FUSE = 4'd2;
	localparam logic [3:0] ST_MUL_FUSE  = 4'd3;
	localparam logic [3:0] ST_LOAD_STEP = 4'd4;
	localparam logic [3:0] ST_MUL_STEP  = 4'd5;
	localparam logic [3:0] ST_LOAD_DRV  = 4'd6;
	localparam logic [3:0] ST_MUL_DRV   = 4'd7;
	localparam logic [3:0] ST_SUM       = 4'd8;
	localparam logic [3:0] ST_FINISH    = 4'd9;

	logic [3:0]              state_q;
	logic [CNT_W-1:0]        cnt_q;
	cfg_t                    cfg_q;
	logic signed [TILT_W-1:0] tilt_q;
	logic                    held_reverse_q;
	logic [DUTY_W-1:0]       held_duty_q;
	logic                    out_valid_q;

	logic signed [PRD_W-1:0] acc0_q, acc1_q, drive_q;
	logic signed [VAL_W-1:0] mcand0_q, mcand1_q, rate_q;
	logic [GAIN_W-1:0]       mplier0_q, mplier1_q;
	logic                    out_reverse_q;
	logic [DUTY_W-1:0]       out_duty_q;
	logic signed [DRIVE_W-1:0] out_drive_q;
	logic signed [TILT_W-1:0]  out_tilt_q;

	logic                    accept, cfg_wr, can_store, is_mul, mul_last;
	logic [REG_IDX_W-1:0]    reg_idx;
	logic [SHIFTED_W-1:0]    accel_shifted, gyro_shifted;
	logic [DIFF_W-1:0]       accel_diff, gyro_diff;
	logic signed [PRD_W-1:0] ext0, ext1;
	logic signed [VAL_W-1:0] angle, rate_new, fuse_in, step_in, tilt_ext, nt;
	logic signed [TILT_W-1:0] tilt_sat;
	logic signed [PRD_W-1:0] drive_clamped, drive_abs;
	logic                    drive_neg, drive_nz;
	logic [DUTY_W-1:0]       mag;
	logic signed [DRIVE_W-1:0] drive_whole;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[APB_ADDR_W-1:2];
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign accept    = samples.valid && samples.ready;
	assign can_store = !out_valid_q || commands.ready;
	assign is_mul    = (state_q == ST_MUL_SENS) || (state_q == ST_MUL_FUSE) ||
		(state_q == ST_MUL_STEP) || (state_q == ST_MUL_DRV);
	assign mul_last  = (cnt_q == CNT_W'(GAIN_W - 1));

	assign samples.ready          = (state_q == ST_IDLE);
	assign commands.valid         = out_valid_q;
	assign commands.motor_reverse = out_reverse_q;
	assign commands.motor_duty    = out_duty_q;
	assign commands.drive_value   = out_drive_q;
	assign commands.tilt_estimate = out_tilt_q;

	always_comb begin
		case (reg_idx)
			REG_ACCEL_OFFSET: prdata = APB_DATA_W'(cfg_q.accel_offset);
			REG_GYRO_OFFSET:  prdata = APB_DATA_W'(cfg_q.gyro_offset);
			REG_ACCEL_GAIN:   prdata = APB_DATA_W'(cfg_q.accel_gain);
			REG_GYRO_GAIN:    prdata = APB_DATA_W'(cfg_q.gyro_gain);
			REG_FUSION_GAIN:  prdata = APB_DATA_W'(cfg_q.fusion_gain);
			REG_STEP_TIME:    prdata = APB_DATA_W'(cfg_q.step_time);
			REG_ANGLE_GAIN:   prdata = APB_DATA_W'(cfg_q.angle_gain);
			REG_RATE_GAIN:    prdata = APB_DATA_W'(cfg_q.rate_gain);
			default:          prdata = '0;
		endcase
	end

	// samples in Q.6, offset taken off in a signed word that always holds the difference
	assign accel_shifted = {samples.accel_sample, {SAMPLE_FRAC{1'b0}}};
	assign gyro_shifted  = {samples.gyro_sample, {SAMPLE_FRAC{1'b0}}};
	assign accel_diff    = DIFF_W'(accel_shifted) - DIFF_W'(cfg_q.accel_offset);
	assign gyro_diff     = DIFF_W'(gyro_shifted) - DIFF_W'(cfg_q.gyro_offset);

	assign ext0 = {{GAIN_W{mcand0_q[VAL_W-1]}}, mcand0_q};
	assign ext1 = {{GAIN_W{mcand1_q[VAL_W-1]}}, mcand1_q};

	always_comb begin
		// arithmetic right shifts are floors, so slices of the product do the rounding
		angle    = acc0_q[VAL_W+ANGLE_SHIFT-1:ANGLE_SHIFT];
		rate_new = acc1_q[VAL_W+ANGLE_SHIFT-1:ANGLE_SHIFT];
		tilt_ext = {{(VAL_W-TILT_W){tilt_q[TILT_W-1]}}, tilt_q};
		fuse_in  = angle - tilt_ext;
		step_in  = acc0_q[PRD_W-1:GAIN_W] + rate_q;
		nt       = tilt_ext + acc0_q[PRD_W-1:GAIN_W];
		if (nt[VAL_W-1:TILT_W-1] != {(VAL_W-TILT_W+1){nt[VAL_W-1]}})
			tilt_sat = nt[VAL_W-1] ? {1'b1, {(TILT_W-1){1'b0}}} : {1'b0, {(TILT_W-1){1'b1}}};
		else
			tilt_sat = nt[TILT_W-1:0];

		if (drive_q > LIM)
			drive_clamped = LIM;
		else if (drive_q < NEG_LIM)
			drive_clamped = NEG_LIM;
		else
			drive_clamped = drive_q;
		drive_neg   = drive_clamped[PRD_W-1];
		drive_nz    = (drive_clamped != '0);
		drive_abs   = drive_neg ? -drive_clamped : drive_clamped;
		mag         = drive_abs[FRAC_DRV+DUTY_W-1:FRAC_DRV];
		drive_whole = drive_neg ? -{1'b0, mag} : {1'b0, mag};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			tilt_q         <= '0;
			held_reverse_q <= 1'b0;
			held_duty_q    <= '0;
			out_valid_q    <= 1'b0;
			cfg_q          <= '{RST_ACCEL_OFFSET, RST_GYRO_OFFSET, RST_ACCEL_GAIN,
				RST_GYRO_GAIN, RST_FUSION_GAIN, RST_STEP_TIME, RST_ANGLE_GAIN,
				RST_RATE_GAIN};
		end else begin
			if (cfg_wr) begin
				case (reg_idx)
					REG_ACCEL_OFFSET: cfg_q.accel_offset <= pwdata[CFG_W-1:0];
					REG_GYRO_OFFSET:  cfg_q.gyro_offset  <= pwdata[CFG_W-1:0];
					REG_ACCEL_GAIN:   cfg_q.accel_gain   <= pwdata[CFG_W-1:0];
					REG_GYRO_GAIN:    cfg_q.gyro_gain    <= pwdata[CFG_W-1:0];
					REG_FUSION_GAIN:  cfg_q.fusion_gain  <= pwdata[CFG_W-1:0];
					REG_STEP_TIME:    cfg_q.step_time    <= pwdata[CFG_W-1:0];
					REG_ANGLE_GAIN:   cfg_q.angle_gain   <= pwdata[CFG_W-1:0];
					REG_RATE_GAIN:    cfg_q.rate_gain    <= pwdata[CFG_W-1:0];
					default: ;
				endcase
			end

			// in the finish state the valid flag is set below instead
			if (out_valid_q && commands.ready && (state_q != ST_FINISH))
				out_valid_q <= 1'b0;

			if (is_mul)
				cnt_q <= cnt_q + 1'b1;

			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept)
						state_q <= ST_MUL_SENS;
				end
				ST_MUL_SENS: if (mul_last) state_q <= ST_LOAD_FUSE;
				ST_LOAD_FUSE: state_q <= ST_MUL_FUSE;
				ST_MUL_FUSE: if (mul_last) state_q <= ST_LOAD_STEP;
				ST_LOAD_STEP: state_q <= ST_MUL_STEP;
				ST_MUL_STEP: if (mul_last) state_q <= ST_LOAD_DRV;
				ST_LOAD_DRV: begin
					tilt_q  <= tilt_sat;
					state_q <= ST_MUL_DRV;
				end
				ST_MUL_DRV: if (mul_last) state_q <= ST_SUM;
				ST_SUM: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (can_store) begin
						// an exactly zero drive keeps the held command
						if (drive_nz) begin
							held_reverse_q <= drive_neg;
							held_duty_q    <= mag;
						end
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (is_mul) begin
			// msb first: shift the partial product and add the multiplicand on a set bit
			acc0_q    <= {acc0_q[PRD_W-2:0], 1'b0} + (mplier0_q[GAIN_W-1] ? ext0 : '0);
			acc1_q    <= {acc1_q[PRD_W-2:0], 1'b0} + (mplier1_q[GAIN_W-1] ? ext1 : '0);
			mplier0_q <= {mplier0_q[GAIN_W-2:0], 1'b0};
			mplier1_q <= {mplier1_q[GAIN_W-2:0], 1'b0};
		end
		case (state_q)
			ST_IDLE: begin
				acc0_q    <= '0;
				acc1_q    <= '0;
				mcand0_q  <= {{(VAL_W-DIFF_W){accel_diff[DIFF_W-1]}}, accel_diff};
				mcand1_q  <= {{(VAL_W-DIFF_W){gyro_diff[DIFF_W-1]}}, gyro_diff};
				mplier0_q <= cfg_q.accel_gain;
				mplier1_q <= cfg_q.gyro_gain;
			end
			ST_LOAD_FUSE: begin
				rate_q    <= rate_new;
				acc0_q    <= '0;
				mcand0_q  <= fuse_in;
				mplier0_q <= cfg_q.fusion_gain;
				mplier1_q <= '0;
			end
			ST_LOAD_STEP: begin
				acc0_q    <= '0;
				mcand0_q  <= step_in;
				mplier0_q <= cfg_q.step_time;
			end
			ST_LOAD_DRV: begin
				acc0_q    <= '0;
				acc1_q    <= '0;
				mcand0_q  <= {{(VAL_W-TILT_W){tilt_sat[TILT_W-1]}}, tilt_sat};
				mcand1_q  <= rate_q;
				mplier0_q <= cfg_q.angle_gain;
				mplier1_q <= cfg_q.rate_gain;
			end
			ST_SUM: drive_q <= acc0_q + acc1_q;
			ST_FINISH: begin
				if (can_store) begin
					out_reverse_q <= drive_nz ? drive_neg : held_reverse_q;
					out_duty_q    <= drive_nz ? mag : held_duty_q;
					out_drive_q   <= drive_whole;
					out_tilt_q    <= tilt_q;
				end
			end
			default: ;
		endcase
	end

endmodule

/* rtl/tfpd_checker.sv */
module tfpd_checker import tfpd_pkg::*; #(
	parameter int DRIVE_LIMIT = 100
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      sample_valid,
	input logic                      sample_ready,
	input logic                      cmd_valid,
	input logic                      cmd_ready,
	input logic                      motor_reverse,
	input logic [DUTY_W-1:0]         motor_duty,
	input logic signed [DRIVE_W-1:0] drive_value,
	input logic signed [TILT_W-1:0]  tilt_estimate,
	input logic                      pready
);

	logic [DUTY_W-1:0] drive_mag;
	assign drive_mag = drive_value[DRIVE_W-1] ? DUTY_W'(-drive_value) : DUTY_W'(drive_value);

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("samples ready straight after a request was taken");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid &&
		$stable({motor_reverse, motor_duty, drive_value, tilt_estimate}))
		else $error("stalled command changed or dropped");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> (motor_duty <= DRIVE_LIMIT) && (drive_value <= DRIVE_LIMIT) &&
		(drive_value >= -DRIVE_LIMIT))
		else $error("drive outside the limit");

	a_cmd_matches_drive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && (drive_value != 0) |->
		(motor_reverse == drive_value[DRIVE_W-1]) && (motor_duty == drive_mag))
		else $error("motor command disagrees with drive value");

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind tilt_fusion_pd_motor_drive_core tfpd_checker #(.DRIVE_LIMIT(DRIVE_LIMIT)) u_tfpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.sample_valid  (samples.valid),
	.sample_ready  (samples.ready),
	.cmd_valid     (commands.valid),
	.cmd_ready     (commands.ready),
	.motor_reverse (commands.motor_reverse),
	.motor_duty    (commands.motor_duty),
	.drive_value   (commands.drive_value),
	.tilt_estimate (commands.tilt_estimate),
	.pready        (pready)
);

/* sim/tb_tilt_fusion_pd_motor_drive_core.sv */
`timescale 1ns / 100ps

module tb_tilt_fusion_pd_motor_drive_core;
	import tfpd_pkg::*;

	localparam int CLK_PERIOD  = 4;
	localparam int DRIVE_LIMIT = 100;
	localparam int SAMPLE_BITS = 10;
	localparam int RAND_PHASES = 6;
	localparam int PHASE_ITEMS = 190;
	localparam int GAP_PERCENT = 6;

	localparam logic DIR_FORWARD = 1'b0;
	localparam logic DIR_REVERSE = 1'b1;

	localparam longint TILT_MAX = (longint'(1) <<< (TILT_W - 1)) - 1;
	localparam longint TILT_MIN = -(longint'(1) <<< (TILT_W - 1));

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] accel;
		logic [SAMPLE_BITS-1:0] gyro;
	} sample_pair_t;

	typedef struct packed {
		logic                      reverse;
		logic [DUTY_W-1:0]         duty;
		logic signed [DRIVE_W-1:0] drive;
		logic signed [TILT_W-1:0]  tilt;
	} motor_cmd_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	tfpd_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
	tfpd_cmd_if cmd_ch ();

	tilt_fusion_pd_motor_drive_core #(
		.DRIVE_LIMIT(DRIVE_LIMIT),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.commands(cmd_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// register shadow and filter state as the block should hold them
	logic [CFG_W-1:0]         regs [8];
	logic [CFG_W-1:0]         rst_vals [8];
	logic signed [TILT_W-1:0] tilt_state;
	logic                     held_rev;
	logic [DUTY_W-1:0]        held_duty;

	sample_pair_t pending_samples [$];
	motor_cmd_t   expected_cmds [$];
	sample_pair_t next_pair;
	motor_cmd_t   want;
	int           err_count;
	logic         no_gaps;

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic note_mismatch(input string what);
		if (err_count < 40)
			$display("%0t mismatch: %s", $realtime, what);
		err_count++;
	endtask

	function automatic motor_cmd_t forecast_drive(input logic [SAMPLE_BITS-1:0] acc,
			input logic [SAMPLE_BITS-1:0] gyr);
		longint     angle, rate, corr, delta, tilt, drive, mag, lim;
		motor_cmd_t cmd;
		lim   = longint'(DRIVE_LIMIT) <<< FRAC_DRV;
		angle = (((longint'(acc) <<< SAMPLE_FRAC) - longint'(regs[REG_ACCEL_OFFSET]))
			* longint'(regs[REG_ACCEL_GAIN])) >>> ANGLE_SHIFT;
		rate  = (((longint'(gyr) <<< SAMPLE_FRAC) - longint'(regs[REG_GYRO_OFFSET]))
			* longint'(regs[REG_GYRO_GAIN])) >>> ANGLE_SHIFT;
		tilt  = longint'(tilt_state);
		corr  = ((angle - tilt) * longint'(regs[REG_FUSION_GAIN])) >>> 16;
		delta = ((corr + rate) * longint'(regs[REG_STEP_TIME])) >>> 16;
		tilt  = tilt + delta;
		if (tilt > TILT_MAX)
			tilt = TILT_MAX;
		if (tilt < TILT_MIN)
			tilt = TILT_MIN;
		tilt_state = tilt[TILT_W-1:0];

		drive = tilt * longint'(regs[REG_ANGLE_GAIN]) + rate * longint'(regs[REG_RATE_GAIN]);
		if (drive > lim)
			drive = lim;
		if (drive < -lim)
			drive = -lim;

		cmd.drive = '0;
		if (drive > 0) begin
			mag       = drive >>> FRAC_DRV;
			held_rev  = DIR_FORWARD;
			held_duty = mag[DUTY_W-1:0];
			cmd.drive = mag[DRIVE_W-1:0];
		end else if (drive < 0) begin
			// magnitude truncated, so the drive rounds toward zero
			mag       = (-drive) >>> FRAC_DRV;
			held_rev  = DIR_REVERSE;
			held_duty = mag[DUTY_W-1:0];
			mag       = -mag;
			cmd.drive = mag[DRIVE_W-1:0];
		end
		// exactly zero drive leaves the held command alone
		cmd.reverse = held_rev;
		cmd.duty    = held_duty;
		cmd.tilt    = tilt_state;
		return cmd;
	endfunction

	// request driver: payload held until taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready)
				expected_cmds.push_back(forecast_drive(sample_ch.accel_sample,
					sample_ch.gyro_sample));
			if (!sample_ch.valid || sample_ch.ready) begin
				if (pending_samples.size() != 0 &&
						(no_gaps || $urandom_range(99) >= GAP_PERCENT)) begin
					next_pair = pending_samples.pop_front();
					sample_ch.valid        <= 1'b1;
					sample_ch.accel_sample <= next_pair.accel;
					sample_ch.gyro_sample  <= next_pair.gyro;
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			cmd_ch.ready <= no_gaps || $urandom_range(99) >= GAP_PERCENT;
	end

	// command monitor
	always @(posedge clk) begin
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			if (expected_cmds.size() == 0) begin
				note_mismatch("motor command with no request outstanding");
			end else begin
				want = expected_cmds.pop_front();
				if (cmd_ch.motor_reverse !== want.reverse)
					note_mismatch($sformatf("motor_reverse %0b, want %0b",
						cmd_ch.motor_reverse, want.reverse));
				if (cmd_ch.motor_duty !== want.duty)
					note_mismatch($sformatf("motor_duty %0d, want %0d",
						cmd_ch.motor_duty, want.duty));
				if (cmd_ch.drive_value !== want.drive)
					note_mismatch($sformatf("drive_value %0d, want %0d",
						cmd_ch.drive_value, want.drive));
				if (cmd_ch.tilt_estimate !== want.tilt)
					note_mismatch($sformatf("tilt_estimate %0d, want %0d",
						cmd_ch.tilt_estimate, want.tilt));
			end
		end
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		psel   <= 1'b1;
		pwrite <= 1'b1;
		paddr  <= {idx, 2'b00};
		pwdata <= APB_DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		regs[idx] = val;
	endtask

	task automatic check_reg(input logic [REG_IDX_W-1:0] idx);
		@(posedge clk);
		psel   <= 1'b1;
		pwrite <= 1'b0;
		paddr  <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DATA_W'(regs[idx]))
			note_mismatch($sformatf("register %0d reads %0h, want %0h", idx, prdata, regs[idx]));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_settings(input logic [CFG_W-1:0] plan [8]);
		for (int i = 0; i < 8; i++)
			write_reg(REG_IDX_W'(i), plan[i]);
		for (int i = 0; i < 8; i++)
			check_reg(REG_IDX_W'(i));
	endtask

	task automatic wait_idle();
		while (pending_samples.size() != 0 || sample_ch.valid || expected_cmds.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic queue_pair(input int acc, input int gyr);
		pending_samples.push_back('{accel: acc[SAMPLE_BITS-1:0], gyro: gyr[SAMPLE_BITS-1:0]});
	endtask

	function automatic logic [CFG_W-1:0] random_setting(input int idx);
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			2, 3:    return rst_vals[idx];
			4, 5:    return rst_vals[idx] ^ CFG_W'($urandom_range(255));
			default: return CFG_W'($urandom);
		endcase
	endfunction

	// mostly uniform, sometimes close to the zero level so drives stay small
	function automatic int random_sample(input logic [CFG_W-1:0] offset);
		int v;
		if ($urandom_range(9) < 7)
			return $urandom_range((1 << SAMPLE_BITS) - 1);
		v = int'(offset >> SAMPLE_FRAC) - 8 + int'($urandom_range(16));
		if (v < 0)
			v = 0;
		if (v > (1 << SAMPLE_BITS) - 1)
			v = (1 << SAMPLE_BITS) - 1;
		return v;
	endfunction

	initial begin
		#2_000_000;
		$display("tb_tilt_fusion_pd_motor_drive_core: done, errors");
		$finish;
	end

	initial begin
		logic [CFG_W-1:0] plan [8];
		clk                    = 1'b0;
		arst_n                 = 1'b0;
		psel                   = 1'b0;
		penable                = 1'b0;
		pwrite                 = 1'b0;
		paddr                  = '0;
		pwdata                 = '0;
		sample_ch.valid        = 1'b0;
		sample_ch.accel_sample = '0;
		sample_ch.gyro_sample  = '0;
		cmd_ch.ready           = 1'b0;
		err_count              = 0;
		no_gaps                = 1'b0;
		tilt_state             = '0;
		held_rev               = DIR_FORWARD;
		held_duty              = '0;
		rst_vals[REG_ACCEL_OFFSET] = RST_ACCEL_OFFSET;
		rst_vals[REG_GYRO_OFFSET]  = RST_GYRO_OFFSET;
		rst_vals[REG_ACCEL_GAIN]   = RST_ACCEL_GAIN;
		rst_vals[REG_GYRO_GAIN]    = RST_GYRO_GAIN;
		rst_vals[REG_FUSION_GAIN]  = RST_FUSION_GAIN;
		rst_vals[REG_STEP_TIME]    = RST_STEP_TIME;
		rst_vals[REG_ANGLE_GAIN]   = RST_ANGLE_GAIN;
		rst_vals[REG_RATE_GAIN]    = RST_RATE_GAIN;
		regs = rst_vals;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < 8; i++)
			check_reg(REG_IDX_W'(i));

		// reset settings: sample extremes and the zero levels
		queue_pair(0, 0);
		queue_pair(1023, 1023);
		queue_pair(0, 1023);
		queue_pair(1023, 0);
		queue_pair(304, 348);
		queue_pair(304, 348);
		wait_idle();

		// every gain flat out: tilt climbs close to its positive ceiling and the drive hits its limit
		plan = '{default: '1};
		plan[REG_ACCEL_OFFSET] = '0;
		plan[REG_GYRO_OFFSET]  = '0;
		apply_settings(plan);
		repeat (3) queue_pair(1023, 1023);
		wait_idle();

		// offsets at the top pull tilt close to its negative floor
		plan = '{default: '1};
		apply_settings(plan);
		repeat (3) queue_pair(0, 0);
		wait_idle();

		// no gain on the drive: zero drive keeps the reverse command from before
		plan = rst_vals;
		plan[REG_ANGLE_GAIN] = '0;
		plan[REG_RATE_GAIN]  = '0;
		apply_settings(plan);
		queue_pair(512, 512);
		queue_pair(1023, 0);
		queue_pair(0, 1023);
		wait_idle();

		// tiny drives from the gyro alone: duty 0 with a sign, then held
		plan = '{default: '0};
		plan[REG_GYRO_OFFSET] = CFG_W'(512 << SAMPLE_FRAC);
		plan[REG_GYRO_GAIN]   = CFG_W'(1);
		plan[REG_RATE_GAIN]   = CFG_W'(1);
		apply_settings(plan);
		queue_pair(0, 513);
		queue_pair(0, 512);
		queue_pair(0, 511);
		queue_pair(1023, 512);
		wait_idle();

		for (int p = 0; p < RAND_PHASES; p++) begin
			for (int i = 0; i < 8; i++)
				plan[i] = (p == RAND_PHASES - 1) ? rst_vals[i] : random_setting(i);
			apply_settings(plan);
			no_gaps = (p == 2);
			repeat (PHASE_ITEMS)
				queue_pair(random_sample(regs[REG_ACCEL_OFFSET]),
					random_sample(regs[REG_GYRO_OFFSET]));
			wait_idle();
			no_gaps = 1'b0;
		end

		repeat (80) @(posedge clk);
		if (err_count == 0)
			$display("tb_tilt_fusion_pd_motor_drive_core: done, clean");
		else
			$display("tb_tilt_fusion_pd_motor_drive_core: done, errors");
		$finish;
	end

endmodule

/* sim.f */
rtl/tfpd_pkg.sv
rtl/tfpd_stream_if.sv
rtl/tilt_fusion_pd_motor_drive_core.sv
rtl/tfpd_checker.sv
sim/tb_tilt_fusion_pd_motor_drive_core.sv
